// ----- sv/lpht_pkg.sv -----
package lpht_pkg;

   // table geometry
   localparam int CAPACITY   = 256;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int HASH_BITS  = 32;
   localparam int MARK_BITS  = 2;
   localparam int ENTRY_BITS = MARK_BITS + KEY_BITS;

   // load limit register
   localparam int LIMIT_BITS = 9;
   localparam int CMP_BITS   = (CNT_BITS + 1 > LIMIT_BITS) ? CNT_BITS + 1 : LIMIT_BITS;

   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [HASH_BITS-1:0]  hash_type;
   typedef logic [MARK_BITS-1:0]  mark_type;
   typedef logic [ENTRY_BITS-1:0] entry_type;
   typedef logic [LIMIT_BITS-1:0] limit_type;
   typedef logic [1:0]            req_code_type;
   typedef logic [1:0]            status_type;

   localparam limit_type LIMIT_RESET = 9'd192;

   // request codes
   localparam req_code_type REQ_GET = 2'd0;
   localparam req_code_type REQ_SET = 2'd1;
   localparam req_code_type REQ_DEL = 2'd2;

   // slot marks
   localparam mark_type MARK_EMPTY = 2'd0;
   localparam mark_type MARK_LIVE  = 2'd1;
   localparam mark_type MARK_TOMB  = 2'd2;

   // result status codes
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_INSERTED  = 2'd1;
   localparam status_type STATUS_NOT_FOUND = 2'd2;
   localparam status_type STATUS_FULL      = 2'd3;

endpackage

// ----- sv/lpht_req_if.sv -----
interface lpht_req_if import lpht_pkg::*; ();

   logic         valid;
   logic         ready;
   req_code_type req_type;
   key_type      key;
   hash_type     probe_hash;
   value_type    new_value;

   modport source (output valid, output req_type, output key, output probe_hash,
                   output new_value, input ready);
   modport sink   (input valid, input req_type, input key, input probe_hash,
                   input new_value, output ready);

endinterface

// ----- sv/lpht_rsp_if.sv -----
interface lpht_rsp_if import lpht_pkg::*; ();

   logic       valid;
   logic       ready;
   status_type status;
   value_type  read_value;

   modport source (output valid, output status, output read_value, input ready);
   modport sink   (input valid, input status, input read_value, output ready);

endinterface

// ----- sv/lpht_ram.sv -----
module lpht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/linear_probe_hash_table_unit.sv -----
// Flow: a request probing k slots (1..CAPACITY) walks them one slot per cycle in the probe
// state; an unused request code skips the walk. The result then waits in the done state until
// the response register is free. Only one request is in the block at a time: the single slot
// read port paces the walk, and the request side is not ready until the block is idle again.
// Reset: synchronous; all slots read empty at once (per-slot valid bits), used count zero,
// load limit 192. Key and value memories are not cleared.
module linear_probe_hash_table_unit import lpht_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   lpht_req_if.sink          req_bus,
   lpht_rsp_if.source        rsp_bus,
   input  logic              csr_wr_en,
   input  limit_type         csr_wr_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROBE = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;

   logic [1:0]    state_ff, state_in;
   idx_type       idx_ff, idx_in;
   cnt_type       cnt_ff, cnt_in;
   logic          tomb_seen_ff, tomb_seen_in;
   idx_type       tomb_idx_ff, tomb_idx_in;
   req_code_type  type_ff, type_in;
   key_type       key_ff, key_in;
   value_type     value_ff, value_in;
   status_type    pend_status_ff, pend_status_in;
   value_type     pend_value_ff, pend_value_in;
   cnt_type       used_ff, used_in;
   limit_type     limit_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   value_type     rsp_value_ff, rsp_value_in;
   logic [CAPACITY-1:0] slot_vld_ff;
   logic          mark_vld_ff;

   // memory ports
   idx_type       rd_addr;
   idx_type       wr_idx;
   logic          ent_we;
   logic          val_we;
   entry_type     ent_wdata;
   entry_type     ent_rdata;
   value_type     val_rdata;

   // current slot decode
   mark_type      cur_mark;
   logic          is_tomb;
   logic          key_hit;
   logic          stop_empty;
   logic          last_slot;
   logic          tomb_any;
   idx_type       tomb_at;
   logic          fits;
   logic          out_free;

   lpht_ram #(.WIDTH(ENTRY_BITS), .DEPTH(CAPACITY)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (wr_idx),
      .wr_data (ent_wdata),
      .rd_addr (rd_addr),
      .rd_data (ent_rdata)
   );

   lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (wr_idx),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (val_rdata)
   );

   // slot under test; a slot never written reads as empty
   assign cur_mark   = mark_vld_ff ? ent_rdata[ENTRY_BITS-1 -: MARK_BITS] : MARK_EMPTY;
   assign is_tomb    = (cur_mark == MARK_TOMB);
   assign key_hit    = (cur_mark == MARK_LIVE) && (ent_rdata[KEY_BITS-1:0] == key_ff);
   assign stop_empty = (cur_mark == MARK_EMPTY);
   assign last_slot  = (cnt_ff == cnt_type'(CAPACITY - 1));
   assign tomb_any   = tomb_seen_ff || is_tomb;
   assign tomb_at    = tomb_seen_ff ? tomb_idx_ff : idx_ff;
   assign fits       = CMP_BITS'({1'b0, used_ff} + 1'b1) <= CMP_BITS'(limit_ff);
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign ent_wdata  = {((type_ff == REQ_DEL) ? MARK_TOMB : MARK_LIVE), key_ff};

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.read_value = rsp_value_ff;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      tomb_seen_in   = tomb_seen_ff;
      tomb_idx_in    = tomb_idx_ff;
      type_in        = type_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      pend_status_in = pend_status_ff;
      pend_value_in  = pend_value_ff;
      used_in        = used_ff;
      ent_we         = 1'b0;
      val_we         = 1'b0;
      wr_idx         = idx_ff;
      rd_addr        = idx_ff + 1'b1;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;

      case (state_ff)
         ST_IDLE: begin
            // read the home slot while the request is taken
            rd_addr = req_bus.probe_hash[IDX_BITS-1:0];
            if (req_bus.valid) begin
               type_in       = req_bus.req_type;
               key_in        = req_bus.key;
               value_in      = req_bus.new_value;
               idx_in        = req_bus.probe_hash[IDX_BITS-1:0];
               cnt_in        = '0;
               tomb_seen_in  = 1'b0;
               pend_value_in = '0;
               if (req_bus.req_type inside {REQ_GET, REQ_SET, REQ_DEL}) begin
                  state_in = ST_PROBE;
               end else begin
                  pend_status_in = STATUS_NOT_FOUND;
                  state_in       = ST_DONE;
               end
            end
         end
         ST_PROBE: begin
            if (key_hit) begin
               // matching key
               pend_status_in = STATUS_OK;
               state_in       = ST_DONE;
               case (type_ff)
                  REQ_GET: pend_value_in = val_rdata;
                  REQ_SET: val_we = 1'b1;
                  REQ_DEL: ent_we = 1'b1;
                  default: pend_status_in = STATUS_NOT_FOUND;
               endcase
            end else if (stop_empty || last_slot) begin
               // walk ended without a match
               state_in = ST_DONE;
               if (type_ff != REQ_SET) begin
                  pend_status_in = STATUS_NOT_FOUND;
               end else if (tomb_any) begin
                  wr_idx         = tomb_at;
                  ent_we         = 1'b1;
                  val_we         = 1'b1;
                  pend_status_in = STATUS_INSERTED;
               end else if (stop_empty && fits) begin
                  ent_we         = 1'b1;
                  val_we         = 1'b1;
                  used_in        = used_ff + 1'b1;
                  pend_status_in = STATUS_INSERTED;
               end else begin
                  pend_status_in = STATUS_FULL;
               end
            end else begin
               // step to the next slot, remember the first tombstone
               idx_in = idx_ff + 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (is_tomb && !tomb_seen_ff) begin
                  tomb_seen_in = 1'b1;
                  tomb_idx_in  = idx_ff;
               end
            end
         end
         ST_DONE: begin
            // hand the result to the output register once it is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_value_in  = pend_value_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         slot_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (ent_we) begin
            slot_vld_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // payload and probe bookkeeping
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      cnt_ff         <= cnt_in;
      tomb_seen_ff   <= tomb_seen_in;
      tomb_idx_ff    <= tomb_idx_in;
      type_ff        <= type_in;
      key_ff         <= key_in;
      value_ff       <= value_in;
      pend_status_ff <= pend_status_in;
      pend_value_ff  <= pend_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_value_ff   <= rsp_value_in;
      mark_vld_ff    <= slot_vld_ff[rd_addr];
   end

endmodule

// ----- dv/tb_linear_probe_hash_table_unit.sv -----
`timescale 1ns / 1ps

module tb_linear_probe_hash_table_unit import lpht_pkg::*; ();

   localparam int     HALF_PERIOD  = 10;
   localparam int     RESET_CYCLES = 6;
   localparam longint CYCLE_LIMIT  = 3_000_000;
   localparam int     POOL_SIZE    = 384;
   localparam int     PHASE_ITEMS  = 320;
   localparam int     HOT_HOME [5] = '{3, 4, 100, 254, 255};

   // request code the block must answer without touching the table
   localparam req_code_type REQ_UNUSED = 2'd3;

   typedef struct packed {
      status_type status;
      value_type  read_value;
   } table_result_type;

   logic      clock = 1'b0;
   logic      reset;
   logic      csr_wr_en;
   limit_type csr_wr_data;

   lpht_req_if req_bus ();
   lpht_rsp_if rsp_bus ();

   linear_probe_hash_table_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // shadow copy of the table contents and the load limit
   key_type   shadow_key   [CAPACITY];
   value_type shadow_value [CAPACITY];
   mark_type  shadow_mark  [CAPACITY];
   int        shadow_used;
   int        shadow_limit;

   table_result_type pending_results [$];
   int            error_count   = 0;
   int            beats_checked = 0;
   int            requests_sent = 0;
   int            status_tally [4] = '{0, 0, 0, 0};
   longint        cycle_count   = 0;
   bit            quiet         = 1'b0;

   // keys with a fixed hash each, so repeated requests find their slots
   key_type  pool_key  [POOL_SIZE];
   hash_type pool_hash [POOL_SIZE];

   // apply one request to the shadow table and return the response it should give
   function automatic table_result_type table_apply(req_code_type op, key_type k, hash_type h,
                                                    value_type v);
      int               idx;
      int               hit;
      int               tomb;
      int               empty;
      table_result_type res;
      res.status     = STATUS_NOT_FOUND;
      res.read_value = '0;
      if (op == REQ_UNUSED) return res;
      idx   = int'(h % CAPACITY);
      hit   = -1;
      tomb  = -1;
      empty = -1;
      // walk at most one lap, stop on a matching key or a never-used slot
      for (int n = 0; n < CAPACITY && hit < 0 && empty < 0; n++) begin
         if (shadow_mark[idx] == MARK_EMPTY) begin
            empty = idx;
         end else begin
            if (shadow_mark[idx] == MARK_TOMB) begin
               if (tomb < 0) tomb = idx;
            end else if (shadow_key[idx] == k) begin
               hit = idx;
            end
            if (hit < 0) idx = (idx + 1) % CAPACITY;
         end
      end
      case (op)
         REQ_GET: begin
            if (hit >= 0) begin
               res.status     = STATUS_OK;
               res.read_value = shadow_value[hit];
            end
         end
         REQ_DEL: begin
            if (hit >= 0) begin
               shadow_mark[hit] = MARK_TOMB;
               res.status       = STATUS_OK;
            end
         end
         default: begin
            if (hit >= 0) begin
               shadow_value[hit] = v;
               res.status        = STATUS_OK;
            end else if (tomb >= 0) begin
               // tombstone reuse does not count against the limit
               shadow_key[tomb]   = k;
               shadow_value[tomb] = v;
               shadow_mark[tomb]  = MARK_LIVE;
               res.status         = STATUS_INSERTED;
            end else if (empty >= 0 && shadow_used + 1 <= shadow_limit) begin
               shadow_key[empty]   = k;
               shadow_value[empty] = v;
               shadow_mark[empty]  = MARK_LIVE;
               shadow_used++;
               res.status          = STATUS_INSERTED;
            end else begin
               res.status = STATUS_FULL;
            end
         end
      endcase
      return res;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // drive one request beat and wait for it to be taken
   task automatic send_request(req_code_type op, key_type k, hash_type h, value_type v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= op;
      req_bus.key        <= k;
      req_bus.probe_hash <= h;
      req_bus.new_value  <= v;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(table_apply(op, k, h, v));
      requests_sent++;
   endtask

   // stop requesting and wait for every outstanding response
   task automatic go_idle();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_load_limit(limit_type limit);
      go_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      shadow_limit = limit;
   endtask

   // mostly pool keys with their own hash, a few stray keys and wrong hashes
   task automatic random_request();
      int           r;
      int           i;
      req_code_type op;
      key_type      k;
      hash_type     h;
      r  = $urandom_range(0, 99);
      op = (r < 38) ? REQ_GET : (r < 72) ? REQ_SET : (r < 94) ? REQ_DEL : REQ_UNUSED;
      i  = $urandom_range(0, POOL_SIZE - 1);
      k  = pool_key[i];
      h  = pool_hash[i];
      r  = $urandom_range(0, 99);
      if (r < 5) begin
         k = $urandom;
         h = $urandom;
      end else if (r < 8) begin
         h = $urandom;
      end
      send_request(op, k, h, $urandom);
   endtask

   // get, set, update, delete, unused code and field extremes on an empty table
   task automatic test_basic_ops();
      send_request(REQ_GET, 32'h1234_5678, 32'hA5A5_0010, 32'h0);
      send_request(REQ_DEL, 32'h1234_5678, 32'hA5A5_0010, 32'h0);
      send_request(REQ_SET, 32'h1234_5678, 32'hA5A5_0010, 32'h0BAD_F00D);
      send_request(REQ_GET, 32'h1234_5678, 32'hA5A5_0010, 32'hFFFF_FFFF);
      send_request(REQ_SET, 32'h1234_5678, 32'hA5A5_0010, 32'hCAFE_0001);
      send_request(REQ_UNUSED, 32'h1234_5678, 32'hA5A5_0010, 32'h5555_5555);
      send_request(REQ_GET, 32'h1234_5678, 32'hA5A5_0010, 32'h0);
      send_request(REQ_SET, 32'h0, 32'h0, 32'h0);
      send_request(REQ_GET, 32'h0, 32'h0, 32'h0);
      send_request(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // three keys homed on the occupied last slot spill over the wrap into slot 1 onward
   task automatic test_collisions_and_wrap();
      send_request(REQ_SET, 32'hC0DE_0001, 32'h0000_00FF, 32'h1111_1111);
      send_request(REQ_SET, 32'hC0DE_0002, 32'h7F00_00FF, 32'h2222_2222);
      send_request(REQ_SET, 32'hC0DE_0003, 32'h8000_00FF, 32'h3333_3333);
      send_request(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_request(REQ_GET, 32'hC0DE_0003, 32'h8000_00FF, 32'h0);
      send_request(REQ_GET, 32'hC0DE_9999, 32'h1234_56FF, 32'h0);
   endtask

   // tombstone in the middle of a chain: lookups pass it, a new key reuses it
   task automatic test_tombstones();
      send_request(REQ_DEL, 32'hC0DE_0002, 32'h7F00_00FF, 32'h0);
      send_request(REQ_GET, 32'hC0DE_0003, 32'h8000_00FF, 32'h0);
      send_request(REQ_SET, 32'hC0DE_0004, 32'h4400_00FF, 32'h4444_4444);
      send_request(REQ_GET, 32'hC0DE_0004, 32'h4400_00FF, 32'h0);
      send_request(REQ_DEL, 32'hC0DE_0004, 32'h4400_00FF, 32'h0);
      send_request(REQ_DEL, 32'hC0DE_0004, 32'h4400_00FF, 32'h0);
   endtask

   // refusal of new keys at the limit, updates and tombstone reuse still allowed
   task automatic test_load_limit();
      set_load_limit('0);
      send_request(REQ_SET, 32'hBEEF_0001, 32'h0000_0040, 32'h1);
      send_request(REQ_SET, 32'h1234_5678, 32'hA5A5_0010, 32'hCAFE_0002);
      send_request(REQ_SET, 32'hBEEF_0002, 32'h0BB0_00FF, 32'h2);
      set_load_limit(limit_type'(shadow_used + 1));
      send_request(REQ_SET, 32'hBEEF_0003, 32'h0000_0041, 32'h3);
      send_request(REQ_SET, 32'hBEEF_0004, 32'h0000_0042, 32'h4);
      send_request(REQ_SET, 32'hBEEF_0003, 32'h0000_0041, 32'h33);
   endtask

   // mixed traffic on a key pool, one phase per load limit setting
   task automatic test_random_traffic();
      int       phase_limit [5] = '{64, 0, 160, 192, 240};
      hash_type h;
      for (int i = 0; i < POOL_SIZE; i++) begin
         h = $urandom;
         if ($urandom_range(0, 3) == 0)
            h[IDX_BITS-1:0] = idx_type'(HOT_HOME[$urandom_range(0, 4)]);
         pool_key[i]  = $urandom;
         pool_hash[i] = h;
      end
      for (int p = 0; p < 5; p++) begin
         set_load_limit(limit_type'(phase_limit[p]));
         quiet = (p == 3);
         repeat (PHASE_ITEMS) random_request();
         quiet = 1'b0;
      end
   endtask

   // fill every slot, then probes run a full lap without finding an empty slot
   task automatic test_probe_exhaustion();
      int       slot;
      int       n_tomb;
      key_type  k;
      hash_type h;
      set_load_limit(limit_type'(CAPACITY));
      while (shadow_used < CAPACITY) begin
         slot = $urandom_range(0, CAPACITY - 1);
         while (shadow_mark[slot] != MARK_EMPTY) slot = (slot + 1) % CAPACITY;
         h = $urandom;
         h[IDX_BITS-1:0] = idx_type'(slot);
         send_request(REQ_SET, $urandom, h, $urandom);
      end
      // new keys soak up the remaining tombstones
      do begin
         n_tomb = 0;
         foreach (shadow_mark[i]) if (shadow_mark[i] == MARK_TOMB) n_tomb++;
         if (n_tomb > 0) send_request(REQ_SET, $urandom, $urandom, $urandom);
      end while (n_tomb > 0);
      send_request(REQ_SET, 32'hDEAD_0001, $urandom, 32'h1);
      send_request(REQ_GET, 32'hDEAD_0001, $urandom, 32'h0);
      send_request(REQ_DEL, 32'hDEAD_0001, $urandom, 32'h0);
      // one tombstone in a full table: a new key lands in it after a full lap
      slot = $urandom_range(0, CAPACITY - 1);
      while (shadow_mark[slot] != MARK_LIVE) slot = (slot + 1) % CAPACITY;
      k = shadow_key[slot];
      h = $urandom;
      h[IDX_BITS-1:0] = idx_type'(slot);
      send_request(REQ_DEL, k, h, 32'h0);
      send_request(REQ_SET, 32'hDEAD_0002, $urandom, 32'h2);
      send_request(REQ_GET, k, h, 32'h0);
      set_load_limit(limit_type'('1));
      repeat (80) random_request();
   endtask

   // response sink with bursts of stalls
   initial begin
      int hold;
      int r;
      rsp_bus.ready <= 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (quiet) begin
            rsp_bus.ready <= 1'b1;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_bus.ready <= 1'b1;
               hold = $urandom_range(0, 8);
            end else if (r < 92) begin
               rsp_bus.ready <= 1'b0;
               hold = $urandom_range(0, 2);
            end else begin
               rsp_bus.ready <= 1'b0;
               hold = $urandom_range(10, 40);
            end
         end
      end
   end

   // compare each response beat with the oldest outstanding prediction
   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response beat with none outstanding: status %0d value %h",
                     $time, rsp_bus.status, rsp_bus.read_value);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.read_value !== want.read_value) begin
               $display("%0t: read_value mismatch, expected %h, actual %h",
                        $time, want.read_value, rsp_bus.read_value);
               error_count++;
            end
            status_tally[want.status]++;
            beats_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout with %0d responses outstanding", $time, pending_results.size());
      $display("linear_probe_hash_table_unit test failed");
      $finish;
   end

   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= REQ_GET;
      req_bus.key        <= '0;
      req_bus.probe_hash <= '0;
      req_bus.new_value  <= '0;
      foreach (shadow_mark[i]) shadow_mark[i] = MARK_EMPTY;
      shadow_used  = 0;
      shadow_limit = LIMIT_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_collisions_and_wrap();
      test_tombstones();
      test_load_limit();
      test_random_traffic();
      test_probe_exhaustion();

      go_idle();
      repeat (CAPACITY + 8) @(posedge clock);
      $display("%0d requests sent, %0d responses checked", requests_sent, beats_checked);
      $display("ok %0d, inserted %0d, missing %0d, full %0d",
               status_tally[STATUS_OK], status_tally[STATUS_INSERTED],
               status_tally[STATUS_NOT_FOUND], status_tally[STATUS_FULL]);
      $display("load limits 0 to 511 swept, table filled to capacity with full-lap probes");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("linear_probe_hash_table_unit test passed");
      end else begin
         $display("linear_probe_hash_table_unit test failed");
      end
      $finish;
   end

endmodule

// ----- linear_probe_hash_table_unit.f -----
sv/lpht_pkg.sv
sv/lpht_req_if.sv
sv/lpht_rsp_if.sv
sv/lpht_ram.sv
sv/linear_probe_hash_table_unit.sv
dv/tb_linear_probe_hash_table_unit.sv
